// File: rtl/core/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg: shared definitions for the coherent binary demodulator
// Widths, register codes, reset values and the quarter-wave sine generator.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int SINE_INDEX_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int ACC_W       = 48;
    localparam int PHASE_W     = 32;
    localparam int COUNT_W     = 16;
    localparam int SINE_W      = 16;
    localparam int ROM_W       = 15;
    localparam int OUT_DEPTH   = 4;

    typedef enum logic [1:0] {
        MODE_ASK = 2'd0,
        MODE_PSK = 2'd1,
        MODE_FSK = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE     = 3'd0,
        CFG_STEP_A   = 3'd1,
        CFG_STEP_B   = 3'd2,
        CFG_SPB      = 3'd3,
        CFG_AMP_THR  = 3'd4,
        CFG_VOTE_THR = 3'd5
    } cfg_index_t;

    localparam logic [1:0]                RST_MODE     = MODE_ASK;
    localparam logic [PHASE_W-1:0]        RST_STEP_A   = 32'd601295;
    localparam logic [PHASE_W-1:0]        RST_STEP_B   = 32'd1202590;
    localparam logic [COUNT_W-1:0]        RST_SPB      = 16'd14286;
    localparam logic signed [ACC_W-1:0]   RST_AMP_THR  = 48'sd6174015488000;
    localparam logic [COUNT_W-1:0]        RST_VOTE_THR = 16'd2310;

    typedef struct packed {
        logic bit_res;
        logic final_res;
    } result_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // Quarter-wave sine entry, Q0.15 magnitude; evaluated at elaboration only
    function automatic logic [ROM_W-1:0] quarter_sine(input int unsigned q,
                                                      input int unsigned qb);
        logic [63:0] x;
        logic [63:0] t;
        longint      sum;
        logic [63:0] scaled;
        x   = (64'(q) * HALF_PI_Q30 + (64'd1 << (qb - 1))) >> qb;
        t   = x;
        sum = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / TAYLOR_DIV[k-1];
            if ((k % 2) == 1)
            begin
                sum = sum - longint'(t);
            end
            else
            begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30))
        begin
            sum = longint'(1) << 30;
        end
        scaled = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        return scaled[ROM_W-1:0];
    endfunction

endpackage

// File: rtl/core/coherent_binary_demodulator_top.sv
// ----------------------------------------------------------------------------
// coherent_binary_demodulator_top: integrate-and-dump ASK/PSK/FSK demodulator
// Local carriers from phase accumulators and a sine ROM, two integrators,
// per-sample decisions and a per-bit vote, with a frame-end tail bit.
// ----------------------------------------------------------------------------
// Results: a result passes the stage 1, stage 2 and stage 3 registers and the result
//   queue before it is offered; a sample that gives two results offers the second one after.
// Throughput: one sample per cycle while in_stall is low, one result per cycle on the output
//   while out_stall is low; the four-entry result queue holds the input while it has fewer than two free.
// Reset: asynchronous, active low; registers return to their defaults and
//   all carrier, integrator and counter state is zero; no clearing pass.
// ----------------------------------------------------------------------------
module coherent_binary_demodulator_top #(
    parameter int SINE_INDEX_BITS = cbd_pkg::SINE_INDEX_BITS_DEF,
    parameter int SAMPLE_BITS     = cbd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [cbd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [cbd_pkg::CFG_DATA_W-1:0]        cfg_data,
    // sample channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  frame_end,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  bit_res,
    output logic                                  final_res
);
    import cbd_pkg::*;

    localparam int QB      = SINE_INDEX_BITS - 2;
    localparam int QUARTER = 1 << QB;
    localparam int ADDR_W  = QB + 1;
    localparam int PROD_W  = SAMPLE_BITS + SINE_W;
    localparam int SUM_W   = ACC_W + 1;
    localparam int PTR_W   = $clog2(OUT_DEPTH);
    localparam int QCNT_W  = PTR_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]                mode_reg;
    logic [PHASE_W-1:0]        step_a_reg;
    logic [PHASE_W-1:0]        step_b_reg;
    logic [COUNT_W-1:0]        spb_reg;
    logic signed [ACC_W-1:0]   amp_thr_reg;
    logic [COUNT_W-1:0]        vote_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= RST_MODE;
            step_a_reg   <= RST_STEP_A;
            step_b_reg   <= RST_STEP_B;
            spb_reg      <= RST_SPB;
            amp_thr_reg  <= RST_AMP_THR;
            vote_thr_reg <= RST_VOTE_THR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:     mode_reg     <= cfg_data[1:0];
                CFG_STEP_A:   step_a_reg   <= cfg_data[PHASE_W-1:0];
                CFG_STEP_B:   step_b_reg   <= cfg_data[PHASE_W-1:0];
                CFG_SPB:      spb_reg      <= cfg_data[COUNT_W-1:0];
                CFG_AMP_THR:  amp_thr_reg  <= $signed(cfg_data[ACC_W-1:0]);
                CFG_VOTE_THR: vote_thr_reg <= cfg_data[COUNT_W-1:0];
                default:      ;  // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. Every stage moves together; advance only while the
    // result queue can take the two results a sample may produce, so no
    // transaction already in flight is ever lost.
    // ------------------------------------------------------------------
    logic [QCNT_W-1:0] q_count_reg;
    logic              adv;
    logic              accept;

    assign adv      = (q_count_reg <= QCNT_W'(OUT_DEPTH - 2));
    assign in_stall = ~adv;
    assign accept   = in_valid & adv;

    // ------------------------------------------------------------------
    // Stage 0: carrier phases and sine ROM lookup at acceptance
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] phase_a_reg, phase_a_next;
    logic [PHASE_W-1:0] phase_b_reg, phase_b_next;

    // Quarter-wave table, QUARTER+1 entries so that the peak is stored
    logic [ROM_W-1:0] quarter_rom [QUARTER+1];
    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_rom
        assign quarter_rom[g] = quarter_sine(g, QB);
    end

    logic [SINE_INDEX_BITS-1:0] idx_a, idx_b;
    logic [ADDR_W-1:0]          addr_a, addr_b;

    assign idx_a = phase_a_reg[PHASE_W-1 -: SINE_INDEX_BITS];
    assign idx_b = phase_b_reg[PHASE_W-1 -: SINE_INDEX_BITS];

    // Odd quadrants read the table backwards from the peak
    assign addr_a = idx_a[QB] ? (ADDR_W'(QUARTER) - {1'b0, idx_a[QB-1:0]})
                              : {1'b0, idx_a[QB-1:0]};
    assign addr_b = idx_b[QB] ? (ADDR_W'(QUARTER) - {1'b0, idx_b[QB-1:0]})
                              : {1'b0, idx_b[QB-1:0]};

    // A frame end returns both carriers to zero phase
    assign phase_a_next = frame_end ? '0 : phase_a_reg + step_a_reg;
    assign phase_b_next = frame_end ? '0 : phase_b_reg + step_b_reg;

    // ------------------------------------------------------------------
    // Stage 1: signed carriers and the two products
    // ------------------------------------------------------------------
    logic                           s1_valid_reg;
    logic                           s1_last_reg;
    logic signed [SAMPLE_BITS-1:0]  s1_sample_reg;
    logic [ROM_W-1:0]               s1_rom_a_reg, s1_rom_b_reg;
    logic                           s1_neg_a_reg, s1_neg_b_reg;

    logic signed [SINE_W-1:0]       sine_a, sine_b;
    logic signed [PROD_W-1:0]       prod_a_next, prod_b_next;

    // Second half of the cycle is negative
    assign sine_a = s1_neg_a_reg ? -$signed({1'b0, s1_rom_a_reg})
                                 :  $signed({1'b0, s1_rom_a_reg});
    assign sine_b = s1_neg_b_reg ? -$signed({1'b0, s1_rom_b_reg})
                                 :  $signed({1'b0, s1_rom_b_reg});

    assign prod_a_next = PROD_W'(s1_sample_reg) * PROD_W'(sine_a);
    assign prod_b_next = PROD_W'(s1_sample_reg) * PROD_W'(sine_b);

    // ------------------------------------------------------------------
    // Stage 2: integrate and dump, samples-per-bit counter
    // ------------------------------------------------------------------
    logic                       s2_valid_reg;
    logic                       s2_last_reg;
    logic signed [PROD_W-1:0]   s2_prod_a_reg, s2_prod_b_reg;

    logic signed [ACC_W-1:0]    integ_a_reg, integ_a_next;
    logic signed [ACC_W-1:0]    integ_b_reg, integ_b_next;
    logic [COUNT_W-1:0]         cnt_reg, cnt_next;

    logic signed [SUM_W-1:0]    sum_a, sum_b;
    logic signed [ACC_W-1:0]    sat_a, sat_b;
    logic signed [ACC_W-1:0]    val_a_next, val_b_next;
    logic [COUNT_W:0]           cnt_inc;
    logic                       wrap_next;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[SUM_W-1] != v[SUM_W-2])
        begin
            r = v[SUM_W-1] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    // Doubled product added to the integrator, saturating to 48 bits
    assign sum_a = SUM_W'(integ_a_reg) + SUM_W'($signed({s2_prod_a_reg, 1'b0}));
    assign sum_b = SUM_W'(integ_b_reg) + SUM_W'($signed({s2_prod_b_reg, 1'b0}));
    assign sat_a = sat_acc(sum_a);
    assign sat_b = sat_acc(sum_b);

    // A lowered period or a zero period wraps on the next sample
    assign cnt_inc   = {1'b0, cnt_reg} + (COUNT_W+1)'(1);
    assign wrap_next = (cnt_inc >= {1'b0, spb_reg});

    // Decision values: integrators after the dump on a wrap
    assign val_a_next = wrap_next ? '0 : sat_a;
    assign val_b_next = wrap_next ? '0 : sat_b;

    always_comb
    begin
        integ_a_next = integ_a_reg;
        integ_b_next = integ_b_reg;
        cnt_next     = cnt_reg;
        if (adv && s2_valid_reg)
        begin
            integ_a_next = s2_last_reg ? '0 : val_a_next;
            integ_b_next = s2_last_reg ? '0 : val_b_next;
            cnt_next     = (wrap_next || s2_last_reg) ? '0 : cnt_inc[COUNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: decision, vote counter and result generation
    // ------------------------------------------------------------------
    logic                       s3_valid_reg;
    logic                       s3_last_reg;
    logic                       s3_wrap_reg;
    logic signed [ACC_W-1:0]    s3_val_a_reg, s3_val_b_reg;

    logic [COUNT_W-1:0]         vote_reg, vote_next;
    logic signed [SUM_W-1:0]    diff;
    logic                       dec;
    logic [COUNT_W-1:0]         vote_inc, vote_after;
    logic                       wrap_bit, tail_bit;
    result_t                    entry0, entry1;
    logic                       push_one, push_two;

    assign diff = SUM_W'(s3_val_b_reg) - SUM_W'(s3_val_a_reg);

    always_comb
    begin
        case (mode_reg)
            MODE_ASK: dec = (s3_val_a_reg > amp_thr_reg);
            MODE_PSK: dec = s3_val_a_reg[ACC_W-1];
            MODE_FSK: dec = ~diff[SUM_W-1] && (diff != '0);
            default:  dec = 1'b0;  // unused mode never votes
        endcase
    end

    // Saturate the vote count rather than wrap
    assign vote_inc   = (dec && (vote_reg != '1)) ? vote_reg + COUNT_W'(1) : vote_reg;
    assign wrap_bit   = (vote_inc >= vote_thr_reg);
    assign vote_after = s3_wrap_reg ? '0 : vote_inc;
    assign tail_bit   = (vote_after >= vote_thr_reg);

    always_comb
    begin
        vote_next = vote_reg;
        if (adv && s3_valid_reg)
        begin
            vote_next = s3_last_reg ? '0 : vote_after;
        end
    end

    // Wrap bit first, tail bit after it; the last one carries the final flag
    always_comb
    begin
        if (s3_wrap_reg)
        begin
            entry0.bit_res   = wrap_bit;
            entry0.final_res = ~s3_last_reg;
        end
        else
        begin
            entry0.bit_res   = tail_bit;
            entry0.final_res = 1'b1;
        end
        entry1.bit_res   = tail_bit;
        entry1.final_res = 1'b1;
    end

    assign push_one = adv & s3_valid_reg & (s3_wrap_reg | s3_last_reg);
    assign push_two = adv & s3_valid_reg & s3_wrap_reg & s3_last_reg;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    result_t            res_q_reg [OUT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  q_count_next;
    logic               pop;
    logic [1:0]         push_cnt;

    assign out_valid = (q_count_reg != '0);
    assign pop       = out_valid & ~out_stall;
    assign bit_res   = res_q_reg[rd_ptr_reg].bit_res;
    assign final_res = res_q_reg[rd_ptr_reg].final_res;

    assign push_cnt     = {push_two, push_one & ~push_two};
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign q_count_next = q_count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_a_reg  <= '0;
            phase_b_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            integ_a_reg  <= '0;
            integ_b_reg  <= '0;
            cnt_reg      <= '0;
            vote_reg     <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            q_count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_a_reg <= phase_a_next;
                phase_b_reg <= phase_b_next;
            end
            if (adv)
            begin
                s1_valid_reg <= in_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            integ_a_reg <= integ_a_next;
            integ_b_reg <= integ_b_next;
            cnt_reg     <= cnt_next;
            vote_reg    <= vote_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: ROM reads, stage data and queue entries
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_last_reg   <= frame_end;
            s1_sample_reg <= sample;
            s1_rom_a_reg  <= quarter_rom[addr_a];
            s1_rom_b_reg  <= quarter_rom[addr_b];
            s1_neg_a_reg  <= idx_a[SINE_INDEX_BITS-1];
            s1_neg_b_reg  <= idx_b[SINE_INDEX_BITS-1];

            s2_last_reg   <= s1_last_reg;
            s2_prod_a_reg <= prod_a_next;
            s2_prod_b_reg <= prod_b_next;

            s3_last_reg   <= s2_last_reg;
            s3_wrap_reg   <= wrap_next;
            s3_val_a_reg  <= val_a_next;
            s3_val_b_reg  <= val_b_next;
        end
        if (push_one)
        begin
            res_q_reg[wr_ptr_reg] <= entry0;
        end
        if (push_two)
        begin
            res_q_reg[wr_ptr_reg + PTR_W'(1)] <= entry1;
        end
    end

endmodule
